>>> rtl/q64_pkg.sv
// Shared types, codes and helpers of the Q64.64 fixed-point ALU.
package q64_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_NEG      = 4'd2,
    OP_ABS      = 4'd3,
    OP_MUL      = 4'd4,
    OP_CMP      = 4'd5,
    OP_FLOOR    = 4'd6,
    OP_CEIL     = 4'd7,
    OP_TRUNC    = 4'd8,
    OP_ROUND    = 4'd9,
    OP_FRAC     = 4'd10,
    OP_FROMFRAC = 4'd11
  } q64_op_t;

  typedef enum logic [1:0] {
    CMP_LESS    = 2'd0,
    CMP_EQUAL   = 2'd1,
    CMP_GREATER = 2'd2,
    CMP_VOID    = 2'd3
  } q64_cmp_t;

  typedef enum logic [1:0] {
    REG_VOID_HI  = 2'd0,
    REG_VOID_LO  = 2'd1,
    REG_VOID_INT = 2'd2
  } q64_reg_t;

  // Work class handed from the front to the back end.
  typedef enum logic [1:0] {
    K_DONE = 2'd0,
    K_MUL  = 2'd1,
    K_DIV  = 2'd2
  } q64_kind_t;

  localparam logic [63:0] HALF_FRAC     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VOID_HI_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VOID_LO_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VOID_INT_RST  = 64'h8000_0000_0000_0000;
  localparam int          JOB_Q_DEPTH   = 4;
  localparam int          RES_Q_DEPTH   = 2;

  typedef struct packed {
    q64_kind_t     kind;
    logic          neg;
    logic [127:0]  x;
    logic [127:0]  y;
    logic [1:0]    cmp;
  } q64_job_t;

  typedef struct packed {
    logic [63:0] res_int;
    logic [63:0] res_fraction;
    logic [1:0]  cmp_code;
  } q64_res_t;

  function automatic logic [127:0] neg128(input logic [127:0] v);
    return (~v) + 128'd1;
  endfunction

endpackage

>>> rtl/q64_64_fixed_point_alu.sv
// Q64.64 fixed-point ALU, top level.
// Signed Q64.64 arithmetic unit with queue-style ports on both sides. Add, sub,
// neg, abs, compare, floor, ceil, trunc, round and frac complete in the front
// end and leave at one beat per cycle while the back end is idle and the result
// queue has room. A multiply holds the back end for a load, sixteen 32x32 limb
// products through one shared multiplier and a final-sign step; a from-fraction
// conversion for a load, 128 steps of restoring division and sign. Results
// leave strictly in input order; a four-entry job queue between front and back
// end keeps taking beats while a long operation runs. The user must write VOID
// patterns via the configuration port while the block is idle; nothing checks.
module q64_64_fixed_point_alu #(
  parameter int JOB_DEPTH = q64_pkg::JOB_Q_DEPTH,
  parameter int RES_DEPTH = q64_pkg::RES_Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [63:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         in_op,
  input  logic signed [63:0] in_a_int,
  input  logic [63:0]        in_a_fraction,
  input  logic signed [63:0] in_b_int,
  input  logic [63:0]        in_b_fraction,
  output logic               empty,
  input  logic               pop,
  output logic signed [63:0] out_res_int,
  output logic [63:0]        out_res_fraction,
  output logic [1:0]         out_cmp_code
);
  import q64_pkg::*;

  q64_job_t job_in, job_out;
  q64_res_t res_in, res_out;
  logic     job_empty, job_pop, res_push, res_full;

  q64_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .op         (in_op),
    .a_int      (in_a_int),
    .a_fraction (in_a_fraction),
    .b_int      (in_b_int),
    .b_fraction (in_b_fraction),
    .job        (job_in)
  );

  q64_fifo #(.WIDTH($bits(q64_job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  q64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  q64_fifo #(.WIDTH($bits(q64_res_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_res_int      = res_out.res_int;
  assign out_res_fraction = res_out.res_fraction;
  assign out_cmp_code     = res_out.cmp_code;

`ifndef SYNTHESIS
  a_job_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> !job_empty)
    else $error("accepted beat did not reach the job queue");

  a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("back end pushed into a full result queue");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (job_pop && job_out.kind == K_DONE) |-> res_push)
    else $error("finished job dropped without a result");
`endif

endmodule

>>> rtl/q64_fifo.sv
// Small register-based queue with one write and one read port.
module q64_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

>>> rtl/q64_front.sv
// Front end: VOID registers, operand checks, combinational operations and job setup.
module q64_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [63:0]           cfg_data,
  input  logic [3:0]            op,
  input  logic signed [63:0]    a_int,
  input  logic [63:0]           a_fraction,
  input  logic signed [63:0]    b_int,
  input  logic [63:0]           b_fraction,
  output q64_pkg::q64_job_t     job
);
  import q64_pkg::*;

  logic [63:0]  void_hi_r, void_lo_r, void_int_r;
  logic [127:0] a, b, vpat, sum, diff, neg_a, abs_a, ma, mb;
  logic [63:0]  an, ad;
  logic         av, anyv, ovf, a_neg, b_neg, lo_nz, up;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      void_hi_r  <= VOID_HI_RST;
      void_lo_r  <= VOID_LO_RST;
      void_int_r <= VOID_INT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_VOID_HI:  void_hi_r  <= cfg_data;
        REG_VOID_LO:  void_lo_r  <= cfg_data;
        REG_VOID_INT: void_int_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    a     = {a_int, a_fraction};
    b     = {b_int, b_fraction};
    vpat  = {void_hi_r, void_lo_r};
    av    = (a == vpat);
    anyv  = av || (b == vpat);
    a_neg = a[127];
    b_neg = b[127];
    lo_nz = (a_fraction != '0);
    sum   = a + b;
    diff  = a - b;
    // Signed overflow: operands agree in sign and the sum does not.
    ovf   = (a_neg == b_neg) && (sum[127] != a_neg);
    neg_a = neg128(a);
    abs_a = a_neg ? neg_a : a;
    ma    = abs_a;
    mb    = b_neg ? neg128(b) : b;
    an    = a_int[63] ? (~a_int) + 64'd1 : a_int;
    ad    = b_int[63] ? (~b_int) + 64'd1 : b_int;
    // Halves round away from zero.
    up    = a_neg ? (a_fraction > HALF_FRAC) : (a_fraction >= HALF_FRAC);

    job      = '0;
    job.kind = K_DONE;
    job.x    = vpat;
    unique case (op)
      OP_ADD:   if (!anyv && !ovf) job.x = sum;
      OP_SUB:   if (!anyv) job.x = diff;
      OP_NEG:   if (!av) job.x = neg_a;
      OP_ABS:   if (!av) job.x = abs_a;
      OP_MUL: begin
        if (!anyv) begin
          job.kind = K_MUL;
          job.neg  = a_neg ^ b_neg;
          job.x    = ma;
          job.y    = mb;
        end
      end
      OP_CMP: begin
        job.x = '0;
        if (anyv) begin
          job.cmp = CMP_VOID;
        end else if ($signed(a) < $signed(b)) begin
          job.cmp = CMP_LESS;
        end else if (a == b) begin
          job.cmp = CMP_EQUAL;
        end else begin
          job.cmp = CMP_GREATER;
        end
      end
      OP_FLOOR: if (!av) job.x = {a_int, 64'd0};
      OP_CEIL:  if (!av) job.x = {a_int + {63'd0, lo_nz}, 64'd0};
      OP_TRUNC: if (!av) job.x = {a_int + {63'd0, a_neg && lo_nz}, 64'd0};
      OP_ROUND: if (!av) job.x = {a_int + {63'd0, up}, 64'd0};
      OP_FRAC: begin
        if (!av) begin
          if (!a_neg) begin
            job.x = {64'd0, a_fraction};
          end else if (!lo_nz) begin
            job.x = '0;
          end else begin
            job.x = {64'hFFFF_FFFF_FFFF_FFFF, a_fraction};
          end
        end
      end
      OP_FROMFRAC: begin
        if (a_int != void_int_r && b_int != void_int_r && b_int != '0) begin
          job.kind = K_DIV;
          job.neg  = a_int[63] ^ b_int[63];
          job.x    = {an, 64'd0};
          job.y    = {64'd0, ad};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/q64_back.sv
// Back end: finished results pass through, multiply and from-fraction iterate.
module q64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  q64_pkg::q64_job_t job,
  input  logic              job_empty,
  output logic              job_pop,
  output logic              res_push,
  output q64_pkg::q64_res_t res,
  input  logic              res_full
);
  import q64_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  localparam logic [6:0] MUL_LAST = 7'd15;
  localparam logic [6:0] DIV_LAST = 7'd127;

  state_t       state_r, state_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [127:0] x_r, x_nxt, y_r, y_nxt, val;
  logic [255:0] acc_r, acc_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic         neg_r, neg_nxt, mul_r, mul_nxt, ge;
  logic [1:0]   li, lj;
  logic [63:0]  prod;
  logic [64:0]  rem_sh;
  logic [2:0]   lsum;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    mul_nxt   = mul_r;
    job_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;

    li     = cnt_r[3:2];
    lj     = cnt_r[1:0];
    lsum   = {1'b0, li} + {1'b0, lj};
    prod   = x_r[{li, 5'd0} +: 32] * y_r[{lj, 5'd0} +: 32];
    rem_sh = {rem_r, x_r[127]};
    ge     = (rem_sh >= {1'b0, y_r[63:0]});
    val    = mul_r ? acc_r[191:64] : x_r;

    unique case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          if (job.kind == K_DONE) begin
            res      = '{res_int: job.x[127:64], res_fraction: job.x[63:0],
                         cmp_code: job.cmp};
            res_push = !res_full;
            job_pop  = !res_full;
          end else begin
            job_pop   = 1'b1;
            x_nxt     = job.x;
            y_nxt     = job.y;
            neg_nxt   = job.neg;
            cnt_nxt   = '0;
            acc_nxt   = '0;
            rem_nxt   = '0;
            mul_nxt   = (job.kind == K_MUL);
            state_nxt = (job.kind == K_MUL) ? S_MUL : S_DIV;
          end
        end
      end
      S_MUL: begin
        // One 32x32 limb product per cycle, added at its limb offset.
        acc_nxt = acc_r + ({192'd0, prod} << {lsum, 5'd0});
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        // Restoring division of {|num|, 64 zero bits} by |den|, one quotient bit a cycle.
        rem_nxt = ge ? 64'(rem_sh - {1'b0, y_r[63:0]}) : rem_sh[63:0];
        x_nxt   = {x_r[126:0], ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        val      = neg_r ? neg128(val) : val;
        res      = '{res_int: val[127:64], res_fraction: val[63:0], cmp_code: CMP_LESS};
        res_push = !res_full;
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    mul_r <= mul_nxt;
  end

endmodule

>>> test/q64_checker.sv
// Checker for the Q64.64 ALU: predicts each result beat and compares it.
`timescale 1ns / 100ps
module q64_checker
  import q64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [3:0]  in_op,
  input  logic [63:0] in_a_int,
  input  logic [63:0] in_a_fraction,
  input  logic [63:0] in_b_int,
  input  logic [63:0] in_b_fraction,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] out_res_int,
  input  logic [63:0] out_res_fraction,
  input  logic [1:0]  out_cmp_code,
  output int          errors,
  output int          pending
);

  logic [63:0] void_hi, void_lo, void_int;
  q64_res_t    want_q[$];

  function automatic q64_res_t alu_result(logic [3:0] op, logic [63:0] ai, logic [63:0] af,
                                          logic [63:0] bi, logic [63:0] bf);
    logic [127:0] a, b, s, ma, mb, qf;
    logic [255:0] p;
    logic [63:0]  an, ad;
    logic         av, anyv, up;
    q64_res_t     r;
    a = {ai, af};
    b = {bi, bf};
    av = (a == {void_hi, void_lo});
    anyv = av || (b == {void_hi, void_lo});
    r.res_int = void_hi;
    r.res_fraction = void_lo;
    r.cmp_code = CMP_LESS;
    case (op)
      OP_ADD: if (!anyv) begin
        s = a + b;
        // Overflow only when both signs agree and the sum's sign flips.
        if (!(a[127] == b[127] && s[127] != a[127])) {r.res_int, r.res_fraction} = s;
      end
      OP_SUB: if (!anyv) {r.res_int, r.res_fraction} = a - b;
      OP_NEG: if (!av) {r.res_int, r.res_fraction} = -a;
      OP_ABS: if (!av) {r.res_int, r.res_fraction} = a[127] ? -a : a;
      OP_MUL: if (!anyv) begin
        ma = a[127] ? -a : a;
        mb = b[127] ? -b : b;
        p = {128'd0, ma} * {128'd0, mb};
        s = p[191:64];
        if (a[127] ^ b[127]) s = -s;
        {r.res_int, r.res_fraction} = s;
      end
      OP_CMP: begin
        r.res_int = '0;
        r.res_fraction = '0;
        if (anyv) r.cmp_code = CMP_VOID;
        else if (a == b) r.cmp_code = CMP_EQUAL;
        else if ($signed(a) < $signed(b)) r.cmp_code = CMP_LESS;
        else r.cmp_code = CMP_GREATER;
      end
      OP_FLOOR: if (!av) {r.res_int, r.res_fraction} = {ai, 64'd0};
      OP_CEIL: if (!av) {r.res_int, r.res_fraction} = {ai + (af != 0), 64'd0};
      OP_TRUNC: if (!av) {r.res_int, r.res_fraction} = {ai + (ai[63] && af != 0), 64'd0};
      OP_ROUND: if (!av) begin
        // Halves go away from zero, so a negative exact half stays put.
        up = ai[63] ? (af > HALF_FRAC) : (af >= HALF_FRAC);
        {r.res_int, r.res_fraction} = {ai + up, 64'd0};
      end
      OP_FRAC: if (!av) begin
        if (!ai[63]) {r.res_int, r.res_fraction} = {64'd0, af};
        else if (af == 0) {r.res_int, r.res_fraction} = '0;
        else {r.res_int, r.res_fraction} = {64'hFFFF_FFFF_FFFF_FFFF, af};
      end
      OP_FROMFRAC: if (ai != void_int && bi != void_int && bi != 0) begin
        an = ai[63] ? -ai : ai;
        ad = bi[63] ? -bi : bi;
        qf = {an, 64'd0} / {64'd0, ad};
        if (ai[63] ^ bi[63]) qf = -qf;
        {r.res_int, r.res_fraction} = qf;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    q64_res_t w;
    if (!rst_n) begin
      void_hi <= VOID_HI_RST;
      void_lo <= VOID_LO_RST;
      void_int <= VOID_INT_RST;
      errors <= 0;
      want_q.delete();
    end else begin
      if (cfg_we) begin
        case (q64_reg_t'(cfg_idx))
          REG_VOID_HI:  void_hi <= cfg_data;
          REG_VOID_LO:  void_lo <= cfg_data;
          REG_VOID_INT: void_int <= cfg_data;
          default: ;
        endcase
      end
      if (push && !full)
        want_q.push_back(alu_result(in_op, in_a_int, in_a_fraction, in_b_int, in_b_fraction));
      if (pop && !empty) begin
        if (want_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: int %h frac %h cmp %0d",
                   $time, out_res_int, out_res_fraction, out_cmp_code);
          errors <= errors + 1;
        end else begin
          w = want_q.pop_front();
          if (w.res_int !== out_res_int || w.res_fraction !== out_res_fraction ||
              w.cmp_code !== out_cmp_code) begin
            $display("%0t: mismatch expected int %h frac %h cmp %0d, got int %h frac %h cmp %0d",
                     $time, w.res_int, w.res_fraction, w.cmp_code,
                     out_res_int, out_res_fraction, out_cmp_code);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/testbench.sv
// Top of the Q64.64 ALU testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import q64_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [63:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [3:0]  in_op = '0;
  logic [63:0] in_a_int = '0, in_a_fraction = '0, in_b_int = '0, in_b_fraction = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_res_int, out_res_fraction;
  logic [1:0]  out_cmp_code;
  int          errors, pending;
  int          stall_cycles = 0;
  bit          steady = 1'b0;
  logic [63:0] cur_hi = VOID_HI_RST, cur_lo = VOID_LO_RST, cur_int = VOID_INT_RST;

  always #2 clk = ~clk;

  q64_64_fixed_point_alu dut (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .push, .full, .in_op,
    .in_a_int, .in_a_fraction, .in_b_int, .in_b_fraction, .empty, .pop,
    .out_res_int, .out_res_fraction, .out_cmp_code
  );

  q64_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .push, .full, .in_op,
    .in_a_int, .in_a_fraction, .in_b_int, .in_b_fraction, .empty, .pop,
    .out_res_int, .out_res_fraction, .out_cmp_code, .errors, .pending
  );

  // Result side: stall with a chance of 7 in a hundred unless in a steady stretch.
  always @(posedge clk) begin
    pop <= rst_n && (steady || $urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(logic [3:0] op, logic [63:0] ai, logic [63:0] af,
                      logic [63:0] bi, logic [63:0] bf);
    if (!steady && $urandom_range(99) < 7) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    in_op <= op;
    in_a_int <= ai;
    in_a_fraction <= af;
    in_b_int <= bi;
    in_b_fraction <= bf;
    do @(posedge clk); while (full);
  endtask

  // Waits for every expected beat, then lets the back end run dry.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // The enable drops again after each write.
  task automatic write_reg(q64_reg_t idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VOID_HI:  cur_hi = data;
      REG_VOID_LO:  cur_lo = data;
      default:      cur_int = data;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_word(bit frac);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return frac ? 64'h8000_0000_0000_0000 : 64'd1;
      5: return 64'($urandom_range(0, 20)) - 64'd10;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_item();
    logic [3:0]  op;
    logic [63:0] ai, af, bi, bf;
    op = ($urandom_range(19) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
    ai = pick_word(0);
    af = pick_word(1);
    bi = pick_word(0);
    bf = pick_word(1);
    if ($urandom_range(9) == 0) begin
      ai = cur_hi;
      af = cur_lo;
    end
    if ($urandom_range(9) == 0) begin
      bi = cur_hi;
      bf = cur_lo;
    end
    if (op == OP_FROMFRAC) begin
      // Now and then force a zero denominator, a sentinel operand or small values.
      case ($urandom_range(7))
        0: bi = '0;
        1: ai = cur_int;
        2: bi = cur_int;
        3: begin
          ai = 64'($urandom_range(0, 200)) - 64'd100;
          bi = 64'($urandom_range(1, 30));
          if ($urandom_range(1)) bi = -bi;
        end
        default: ;
      endcase
    end
    send(op, ai, af, bi, bf);
  endtask

  initial begin
    q64_op_t op;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation on extreme and special operands.
    op = op.first();
    do begin
      send(op, 64'h7FFF_FFFF_FFFF_FFFF, '1, 64'h8000_0000_0000_0000, 64'd0);
      op = op.next();
    end while (op != op.first());
    send(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, '1, 64'd0, 64'd1);
    send(OP_ADD, 64'h8000_0000_0000_0000, 64'd0, '1, '0);
    send(OP_MUL, '1, '1, 64'd3, 64'd0);
    send(OP_CMP, 64'd5, 64'd7, 64'd5, 64'd7);
    send(OP_CMP, '1, '1, 64'd0, 64'd0);
    send(OP_ROUND, '1, HALF_FRAC, 64'd0, 64'd0);
    send(OP_ROUND, 64'd2, HALF_FRAC, 64'd0, 64'd0);
    send(OP_FRAC, '1, 64'd0, 64'd0, 64'd0);
    send(OP_FROMFRAC, 64'd1, 64'd1, 64'd0, 64'd0);
    send(OP_FROMFRAC, 64'h8000_0000_0000_0000, 64'd0, '1, 64'd0);
    send(OP_FROMFRAC, -64'd7, 64'd0, 64'd3, 64'd0);
    send(4'($urandom_range(12, 15)), 64'd1, 64'd2, 64'd3, 64'd4);
    drain();

    // Phases under several VOID settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_VOID_HI, 64'h8000_0000_0000_0000);
          write_reg(REG_VOID_LO, 64'd0);
          write_reg(REG_VOID_INT, 64'h7FFF_FFFF_FFFF_FFFF);
        end
        2: begin
          write_reg(REG_VOID_HI, 64'h7FFF_FFFF_FFFF_FFFF);
          write_reg(REG_VOID_LO, '1);
          write_reg(REG_VOID_INT, 64'd0);
        end
        3: begin
          write_reg(REG_VOID_HI, {$urandom, $urandom});
          write_reg(REG_VOID_LO, {$urandom, $urandom});
          write_reg(REG_VOID_INT, '1);
        end
        default: ;
      endcase
      steady = (ph == 2);
      repeat (100) random_item();
      drain();
    end
    steady = 1'b0;

    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
